@@ hw/rtl/frlp_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package frlp_pkg;

    localparam int NAME_BYTES_DEF  = 32;
    localparam int LENGTH_BITS_DEF = 32;

    localparam logic [7:0] NEWLINE_CHAR = 8'd10;
    localparam logic [7:0] SPACE_CHAR   = 8'd32;
    localparam logic [7:0] HEADER_MARK  = 8'd62;

    typedef struct packed {
        logic step;
        logic rd_issue;
        logic load_name;
        logic load_len;
    } frlp_cmd_t;

    typedef struct packed {
        logic emit_req;
        logic name_left;
        logic out_last;
    } frlp_status_t;

endpackage

`default_nettype wire

@@ hw/rtl/frlp_ram.sv @@
`timescale 1ns / 1ps
`default_nettype none

module frlp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  wire logic                                  aclk,
    input  wire logic                                  we,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                      wdata,
    input  wire logic                                  re,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                      rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

@@ hw/rtl/frlp_ctrl.sv @@
`timescale 1ns / 1ps
`default_nettype none

module frlp_ctrl (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  s_valid,
    output logic                       s_ready,
    output logic                       m_valid,
    input  wire logic                  m_ready,
    output frlp_pkg::frlp_cmd_t        cmd,
    input  wire frlp_pkg::frlp_status_t status
);

    import frlp_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_FETCH,
        ST_SHOW
    } state_t;

    state_t state_reg;
    logic   s_ready_reg;
    logic   m_valid_reg;

    assign s_ready = s_ready_reg;
    assign m_valid = m_valid_reg;

    always_comb begin
        cmd.step      = s_valid && s_ready_reg;
        cmd.rd_issue  = (state_reg == ST_READ) && status.name_left;
        cmd.load_len  = (state_reg == ST_READ) && !status.name_left;
        cmd.load_name = (state_reg == ST_FETCH);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            s_ready_reg <= 1'b1;
            m_valid_reg <= 1'b0;
        end else begin
            case (state_reg)
                ST_IDLE: begin
                    if (s_valid && s_ready_reg && status.emit_req) begin
                        s_ready_reg <= 1'b0;
                        state_reg   <= ST_READ;
                    end
                end
                ST_READ: begin
                    if (status.name_left) begin
                        state_reg <= ST_FETCH;
                    end else begin
                        m_valid_reg <= 1'b1;
                        state_reg   <= ST_SHOW;
                    end
                end
                ST_FETCH: begin
                    m_valid_reg <= 1'b1;
                    state_reg   <= ST_SHOW;
                end
                ST_SHOW: begin
                    if (m_ready) begin
                        m_valid_reg <= 1'b0;
                        if (status.out_last) begin
                            s_ready_reg <= 1'b1;
                            state_reg   <= ST_IDLE;
                        end else begin
                            state_reg <= ST_READ;
                        end
                    end
                end
                default: begin
                    state_reg   <= ST_IDLE;
                    s_ready_reg <= 1'b1;
                    m_valid_reg <= 1'b0;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

@@ hw/rtl/frlp_datapath.sv @@
`timescale 1ns / 1ps
`default_nettype none

module frlp_datapath #(
    parameter int NAME_BYTES  = frlp_pkg::NAME_BYTES_DEF,
    parameter int LENGTH_BITS = frlp_pkg::LENGTH_BITS_DEF
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic [7:0]          s_text_byte,
    input  wire logic                s_end_of_input,
    input  wire frlp_pkg::frlp_cmd_t cmd,
    output frlp_pkg::frlp_status_t   status,
    output logic                     m_is_length,
    output logic [7:0]               m_name_byte,
    output logic [31:0]              m_record_length,
    output logic                     m_name_truncated,
    output logic                     m_last
);

    import frlp_pkg::*;

    localparam int ADDR_W = (NAME_BYTES > 1) ? $clog2(NAME_BYTES) : 1;
    localparam int CNT_W  = $clog2(NAME_BYTES + 1);
    localparam int SUM_W  = ((LENGTH_BITS > 32) ? LENGTH_BITS : 32) + 1;

    typedef enum logic [1:0] {
        KIND_START,
        KIND_HEADER,
        KIND_SEQ
    } line_kind_t;

    logic [CNT_W-1:0]       name_count_reg,  name_count_next;
    logic                   record_open_reg, record_open_next;
    logic                   pending_reg,     pending_next;
    logic                   trunc_reg,       trunc_next;
    line_kind_t             kind_reg,        kind_next;
    logic                   collect_reg,     collect_next;
    logic [31:0]            line_count_reg,  line_count_next;
    logic                   line_space_reg,  line_space_next;
    logic [LENGTH_BITS-1:0] total_reg,       total_next;

    logic [CNT_W-1:0] emit_cnt_reg;
    logic             emit_trunc_reg;
    logic [31:0]      emit_len_reg;
    logic [CNT_W-1:0] idx_reg;

    logic             emit_req;
    logic             wr_en;
    logic [SUM_W-1:0] sum;
    logic             sum_sat;
    logic [SUM_W-1:0] total_wide;
    logic [31:0]      len_clip;
    logic [7:0]       rdata;

    assign sum        = SUM_W'(total_reg) + SUM_W'(line_count_reg);
    assign sum_sat    = (sum[SUM_W-1:LENGTH_BITS] != '0);
    assign total_wide = SUM_W'(total_reg);
    assign len_clip   = (total_wide[SUM_W-1:32] != '0) ? '1 : total_wide[31:0];

    always_comb begin
        name_count_next  = name_count_reg;
        record_open_next = record_open_reg;
        pending_next     = pending_reg;
        trunc_next       = trunc_reg;
        kind_next        = kind_reg;
        collect_next     = collect_reg;
        line_count_next  = line_count_reg;
        line_space_next  = line_space_reg;
        total_next       = total_reg;
        emit_req         = 1'b0;
        wr_en            = 1'b0;

        if (s_end_of_input) begin
            emit_req         = record_open_reg;
            name_count_next  = '0;
            record_open_next = 1'b0;
            pending_next     = 1'b0;
            trunc_next       = 1'b0;
            kind_next        = KIND_START;
            collect_next     = 1'b0;
            line_count_next  = '0;
            line_space_next  = 1'b0;
            total_next       = '0;
        end else if (s_text_byte == NEWLINE_CHAR) begin
            case (kind_reg)
                KIND_START: begin
                    emit_req = record_open_reg;
                    if (record_open_reg) begin
                        name_count_next  = '0;
                        record_open_next = 1'b0;
                        pending_next     = 1'b0;
                        trunc_next       = 1'b0;
                        total_next       = '0;
                    end
                end
                KIND_HEADER: begin
                    pending_next     = 1'b0;
                    record_open_next = (name_count_reg != '0);
                    total_next       = '0;
                end
                KIND_SEQ: begin
                    if (record_open_reg) begin
                        if (line_space_reg) begin
                            name_count_next  = '0;
                            record_open_next = 1'b0;
                            pending_next     = 1'b0;
                            trunc_next       = 1'b0;
                            total_next       = '0;
                        end else begin
                            total_next = sum_sat ? '1 : sum[LENGTH_BITS-1:0];
                        end
                    end
                end
                default: begin
                end
            endcase
            kind_next       = KIND_START;
            collect_next    = 1'b0;
            line_count_next = '0;
            line_space_next = 1'b0;
        end else if (kind_reg == KIND_START && s_text_byte == HEADER_MARK) begin
            emit_req         = record_open_reg;
            name_count_next  = '0;
            record_open_next = 1'b0;
            trunc_next       = 1'b0;
            total_next       = '0;
            pending_next     = 1'b1;
            collect_next     = 1'b1;
            kind_next        = KIND_HEADER;
        end else if (kind_reg == KIND_HEADER) begin
            if (collect_reg) begin
                if (s_text_byte == SPACE_CHAR) begin
                    collect_next = 1'b0;
                end else if (name_count_reg < CNT_W'(NAME_BYTES)) begin
                    wr_en           = 1'b1;
                    name_count_next = name_count_reg + 1'b1;
                end else begin
                    trunc_next = 1'b1;
                end
            end
        end else begin
            kind_next = KIND_SEQ;
            if (line_count_reg != '1) begin
                line_count_next = line_count_reg + 1'b1;
            end
            if (s_text_byte == SPACE_CHAR) begin
                line_space_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            name_count_reg  <= '0;
            record_open_reg <= 1'b0;
            pending_reg     <= 1'b0;
            trunc_reg       <= 1'b0;
            kind_reg        <= KIND_START;
            collect_reg     <= 1'b0;
            line_count_reg  <= '0;
            line_space_reg  <= 1'b0;
            total_reg       <= '0;
        end else if (cmd.step) begin
            name_count_reg  <= name_count_next;
            record_open_reg <= record_open_next;
            pending_reg     <= pending_next;
            trunc_reg       <= trunc_next;
            kind_reg        <= kind_next;
            collect_reg     <= collect_next;
            line_count_reg  <= line_count_next;
            line_space_reg  <= line_space_next;
            total_reg       <= total_next;
        end
    end

    // snapshot of the record being emitted, taken before it is cleared
    always_ff @(posedge aclk) begin
        if (cmd.step) begin
            emit_cnt_reg   <= name_count_reg;
            emit_trunc_reg <= trunc_reg;
            emit_len_reg   <= len_clip;
            idx_reg        <= '0;
        end else if (cmd.load_name) begin
            idx_reg <= idx_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_name) begin
            m_is_length      <= 1'b0;
            m_name_byte      <= rdata;
            m_record_length  <= '0;
            m_name_truncated <= emit_trunc_reg;
            m_last           <= 1'b0;
        end else if (cmd.load_len) begin
            m_is_length      <= 1'b1;
            m_name_byte      <= '0;
            m_record_length  <= emit_len_reg;
            m_name_truncated <= emit_trunc_reg;
            m_last           <= 1'b1;
        end
    end

    frlp_ram #(
        .WIDTH (8),
        .DEPTH (NAME_BYTES)
    ) u_name_ram (
        .aclk  (aclk),
        .we    (cmd.step && wr_en),
        .waddr (name_count_reg[ADDR_W-1:0]),
        .wdata (s_text_byte),
        .re    (cmd.rd_issue),
        .raddr (idx_reg[ADDR_W-1:0]),
        .rdata (rdata)
    );

    always_comb begin
        status.emit_req  = emit_req;
        status.name_left = (idx_reg != emit_cnt_reg);
        status.out_last  = m_last;
    end

endmodule

`default_nettype wire

@@ hw/rtl/fasta_record_length_parser.sv @@
`timescale 1ns / 1ps
`default_nettype none

// channel  direction  handshake          payload
// s_       in         s_valid/s_ready    s_text_byte, s_end_of_input
// m_       out        m_valid/m_ready    m_is_length, m_name_byte, m_record_length,
//                                        m_name_truncated, m_last
//
// one text word per cycle while no record is being emitted
// a word that closes a record drops s_ready; emission then steps through, per
// name byte, a ram read issue, a registered read load and the word shown, then a
// length load and the length word shown, each word held while m_ready stays low;
// s_ready returns the cycle after the last word
// synchronous active-low reset clears all line and record state

module fasta_record_length_parser #(
    parameter int NAME_BYTES  = frlp_pkg::NAME_BYTES_DEF,
    parameter int LENGTH_BITS = frlp_pkg::LENGTH_BITS_DEF
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [7:0]  s_text_byte,
    input  wire logic        s_end_of_input,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic             m_is_length,
    output logic [7:0]       m_name_byte,
    output logic [31:0]      m_record_length,
    output logic             m_name_truncated,
    output logic             m_last
);

    import frlp_pkg::*;

    frlp_cmd_t    cmd;
    frlp_status_t status;

    frlp_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (cmd),
        .status  (status)
    );

    frlp_datapath #(
        .NAME_BYTES  (NAME_BYTES),
        .LENGTH_BITS (LENGTH_BITS)
    ) u_datapath (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_text_byte      (s_text_byte),
        .s_end_of_input   (s_end_of_input),
        .cmd              (cmd),
        .status           (status),
        .m_is_length      (m_is_length),
        .m_name_byte      (m_name_byte),
        .m_record_length  (m_record_length),
        .m_name_truncated (m_name_truncated),
        .m_last           (m_last)
    );

    a_no_input_during_emit: assert property (
        @(posedge aclk) disable iff (!aresetn)
        !(s_ready && m_valid)
    ) else $error("input ready while a result word is pending");

    a_ready_after_last: assert property (
        @(posedge aclk) disable iff (!aresetn)
        (m_valid && m_ready && m_last) |=> (s_ready && !m_valid)
    ) else $error("input not reopened after length word");

    a_length_is_last: assert property (
        @(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_is_length == m_last)
    ) else $error("length word and last flag disagree");

    a_name_word_zero_length: assert property (
        @(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_is_length) |-> (m_record_length == 32'd0)
    ) else $error("name word carries a length");

endmodule

`default_nettype wire

@@ dv/tb_top.sv @@
`timescale 1ns / 1ps

import frlp_pkg::*;

localparam int NAME_LIMIT = NAME_BYTES_DEF;
localparam logic [7:0] CR_CHAR = 8'd13;

typedef enum logic [1:0] {
    AT_LINE_START,
    IN_HEADER,
    IN_SEQUENCE
} line_kind_t;

typedef struct packed {
    logic        is_length;
    logic [7:0]  name_byte;
    logic [31:0] record_length;
    logic        name_truncated;
    logic        last;
} record_word_t;

class record_tracker;
    record_word_t expected_record_words[$];
    int unsigned  failures;

    logic [7:0]   name_buf [NAME_LIMIT];
    int unsigned  name_len;
    bit           record_open;
    bit           header_pending;
    bit           name_clipped;
    bit           taking_name;
    bit           seq_has_space;
    line_kind_t   kind;
    logic [31:0]  line_len;
    logic [31:0]  length_sum;

    function new();
        failures = 0;
        reset_state();
    endfunction

    function void clear_record();
        name_len       = 0;
        record_open    = 1'b0;
        header_pending = 1'b0;
        name_clipped   = 1'b0;
        length_sum     = '0;
    endfunction

    function void reset_state();
        clear_record();
        kind          = AT_LINE_START;
        taking_name   = 1'b0;
        line_len      = '0;
        seq_has_space = 1'b0;
    endfunction

    function void queue_word(record_word_t w);
        expected_record_words = {expected_record_words, w};
    endfunction

    // name words, then the length word; closes the record
    function void emit_record();
        record_word_t w;
        if (!record_open) return;
        for (int i = 0; i < name_len; i++) begin
            w.is_length      = 1'b0;
            w.name_byte      = name_buf[i];
            w.record_length  = '0;
            w.name_truncated = name_clipped;
            w.last           = 1'b0;
            queue_word(w);
        end
        w.is_length      = 1'b1;
        w.name_byte      = '0;
        w.record_length  = length_sum;
        w.name_truncated = name_clipped;
        w.last           = 1'b1;
        queue_word(w);
        clear_record();
    endfunction

    function void note_text_word(logic [7:0] b, logic eoi);
        logic [32:0] wide_sum;
        if (eoi) begin
            if (header_pending) clear_record();
            emit_record();
            reset_state();
            return;
        end
        if (b == NEWLINE_CHAR) begin
            case (kind)
                AT_LINE_START: begin
                    emit_record();
                end
                IN_HEADER: begin
                    header_pending = 1'b0;
                    record_open    = (name_len > 0);
                    length_sum     = '0;
                end
                default: begin
                    if (record_open) begin
                        if (seq_has_space) begin
                            clear_record();
                        end else begin
                            wide_sum   = {1'b0, length_sum} + {1'b0, line_len};
                            length_sum = wide_sum[32] ? '1 : wide_sum[31:0];
                        end
                    end
                end
            endcase
            kind          = AT_LINE_START;
            taking_name   = 1'b0;
            line_len      = '0;
            seq_has_space = 1'b0;
            return;
        end
        if (kind == AT_LINE_START) begin
            if (b == HEADER_MARK) begin
                emit_record();
                clear_record();
                header_pending = 1'b1;
                taking_name    = 1'b1;
                kind           = IN_HEADER;
                return;
            end
            kind = IN_SEQUENCE;
        end
        if (kind == IN_HEADER) begin
            if (taking_name) begin
                if (b == SPACE_CHAR) begin
                    taking_name = 1'b0;
                end else if (name_len < NAME_LIMIT) begin
                    name_buf[name_len] = b;
                    name_len++;
                end else begin
                    name_clipped = 1'b1;
                end
            end
        end else begin
            if (line_len != '1) line_len++;
            if (b == SPACE_CHAR) seq_has_space = 1'b1;
        end
    endfunction

    function void report_field(string field, logic [31:0] e, logic [31:0] a);
        if (a !== e) begin
            $display("%0t: %s expected %0h actual %0h", $time, field, e, a);
            failures++;
        end
    endfunction

    function void check_record_word(record_word_t got);
        record_word_t exp;
        if (expected_record_words.size() == 0) begin
            $display("%0t: unexpected word is_length %0h name_byte %0h length %0h",
                     $time, got.is_length, got.name_byte, got.record_length);
            failures++;
            return;
        end
        exp = expected_record_words.pop_front();
        report_field("m_is_length", 32'(exp.is_length), 32'(got.is_length));
        report_field("m_name_byte", 32'(exp.name_byte), 32'(got.name_byte));
        report_field("m_record_length", exp.record_length, got.record_length);
        report_field("m_name_truncated", 32'(exp.name_truncated), 32'(got.name_truncated));
        report_field("m_last", 32'(exp.last), 32'(got.last));
    endfunction
endclass

module tb_top;

    localparam int QUIET_LIMIT  = 4000;
    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_CYCLES = 8;
    localparam int PHASE_WORDS  = 76;

    logic        aclk;
    logic        aresetn          = 1'b0;
    logic        s_valid          = 1'b0;
    logic        s_ready;
    logic [7:0]  s_text_byte      = 8'd0;
    logic        s_end_of_input   = 1'b0;
    logic        m_valid;
    logic        m_ready          = 1'b0;
    logic        m_is_length;
    logic [7:0]  m_name_byte;
    logic [31:0] m_record_length;
    logic        m_name_truncated;
    logic        m_last;

    record_tracker tracker = new();

    int    sender_idle_pct    = 0;
    int    receiver_stall_pct = 0;
    int    words_sent         = 0;
    int    quiet_cycles       = 0;
    bit    hold_request       = 1'b0;
    string bases              = "ACGTN";

    fasta_record_length_parser u_dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_text_byte      (s_text_byte),
        .s_end_of_input   (s_end_of_input),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_is_length      (m_is_length),
        .m_name_byte      (m_name_byte),
        .m_record_length  (m_record_length),
        .m_name_truncated (m_name_truncated),
        .m_last           (m_last)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    task automatic send_word(input logic [7:0] b, input logic eoi);
        while ($urandom_range(99, 0) < sender_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid        <= 1'b1;
        s_text_byte    <= b;
        s_end_of_input <= eoi;
        do @(posedge aclk); while (s_ready !== 1'b1);
        tracker.note_text_word(b, eoi);
        words_sent++;
    endtask

    task automatic send_text(input string txt);
        for (int i = 0; i < txt.len(); i++) send_word(txt[i], 1'b0);
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        while (tracker.expected_record_words.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    function automatic logic [7:0] pick_name_byte();
        logic [7:0] b;
        do b = 8'($urandom_range(255, 0)); while (b == NEWLINE_CHAR || b == SPACE_CHAR);
        return b;
    endfunction

    function automatic logic [7:0] pick_base(bit first);
        logic [7:0] b;
        if ($urandom_range(9, 0) != 0) return bases[$urandom_range(4, 0)];
        do b = 8'($urandom_range(255, 0));
        while (b == NEWLINE_CHAR || (first && b == HEADER_MARK));
        return b;
    endfunction

    // arbitrary bytes up to, optionally, a newline
    task automatic send_noise(input bit with_newline);
        logic [7:0] b;
        repeat ($urandom_range(6, 1)) begin
            do b = 8'($urandom_range(255, 0)); while (b == NEWLINE_CHAR);
            send_word(b, 1'b0);
        end
        if (with_newline) send_word(NEWLINE_CHAR, 1'b0);
    endtask

    task automatic send_sequence_line();
        int n;
        int space_at;
        bit cr;
        n        = $urandom_range(12, 1);
        space_at = ($urandom_range(19, 0) == 0) ? $urandom_range(n - 1, 0) : -1;
        cr       = ($urandom_range(3, 0) == 0);
        for (int i = 0; i < n; i++) begin
            if (i == space_at) send_word(SPACE_CHAR, 1'b0);
            else if (cr && i == n - 1) send_word(CR_CHAR, 1'b0);
            else send_word(pick_base(i == 0), 1'b0);
        end
        send_word(NEWLINE_CHAR, 1'b0);
    endtask

    task automatic send_random_record();
        int sel;
        int name_len;
        sel = $urandom_range(99, 0);
        if (sel < 6) name_len = 0;
        else if (sel < 14) name_len = $urandom_range(40, 30);
        else name_len = $urandom_range(8, 1);
        send_word(HEADER_MARK, 1'b0);
        repeat (name_len) send_word(pick_name_byte(), 1'b0);
        if ($urandom_range(9, 0) < 3) begin
            send_word(SPACE_CHAR, 1'b0);
            send_noise(1'b0);
        end
        send_word(NEWLINE_CHAR, 1'b0);
        repeat ($urandom_range(3, 0)) send_sequence_line();
        if ($urandom_range(4, 0) == 0) send_word(NEWLINE_CHAR, 1'b0);
    endtask

    task automatic send_random_chunk();
        int pick;
        pick = $urandom_range(99, 0);
        if (pick < 78) begin
            send_random_record();
        end else if (pick < 90) begin
            send_noise(1'b1);
        end else begin
            // end of stream, sometimes cutting a line short
            if ($urandom_range(1, 0) == 1) send_noise(1'b0);
            send_word(8'($urandom_range(255, 0)), 1'b1);
        end
    endtask

    // receiver: ready pattern, long hold-off on request, result checks
    initial begin
        int           hold_left;
        record_word_t got;
        hold_left = 0;
        forever begin
            @(posedge aclk);
            if (aresetn && m_valid === 1'b1 && m_ready) begin
                got.is_length      = m_is_length;
                got.name_byte      = m_name_byte;
                got.record_length  = m_record_length;
                got.name_truncated = m_name_truncated;
                got.last           = m_last;
                tracker.check_record_word(got);
            end
            if (hold_request) begin
                hold_request = 1'b0;
                hold_left    = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                m_ready <= 1'b0;
                hold_left--;
            end else begin
                m_ready <= ($urandom_range(99, 0) >= receiver_stall_pct);
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("fasta_record_length_parser: mismatch");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        int sender_pcts[4];
        int receiver_pcts[4];
        int target;
        sender_pcts   = '{0, 84, 0, 15};
        receiver_pcts = '{0, 0, 84, 15};
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: cr in length, empty line close, orphan sequence, empty name,
        // spaced sequence discard, extreme name bytes, flush at end of stream
        send_text(">a x\nAC\015\n\nG\n>\n>b\nA C\n>");
        send_word(8'h00, 1'b0);
        send_word(8'hff, 1'b0);
        send_word(NEWLINE_CHAR, 1'b0);
        send_word(8'h5a, 1'b1);
        wait_drained();

        for (int phase = 0; phase < 4; phase++) begin
            sender_idle_pct    = sender_pcts[phase];
            receiver_stall_pct = receiver_pcts[phase];
            if (phase == 0) hold_request = 1'b1;
            target = words_sent + PHASE_WORDS;
            while (words_sent < target) send_random_chunk();
            wait_drained();
        end

        if (tracker.failures == 0) begin
            $display("fasta_record_length_parser: match");
        end else begin
            $display("fasta_record_length_parser: mismatch");
        end
        $finish;
    end

endmodule

@@ sim.f @@
hw/rtl/frlp_pkg.sv
hw/rtl/frlp_ram.sv
hw/rtl/frlp_ctrl.sv
hw/rtl/frlp_datapath.sv
hw/rtl/fasta_record_length_parser.sv
dv/tb_top.sv
